/* sv/wmcts_pkg.sv */
// shared types, constants and helper functions for the target selector
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package wmcts_pkg;

    // field and datapath widths
    localparam int DIST_W   = 16;
    localparam int ROBOT_W  = 10;
    localparam int PKG_W    = 12;
    localparam int LOC_W    = 16;
    localparam int BIN_W    = 12;
    localparam int COST_W   = 56;
    localparam int COEF_W   = 12;
    localparam int COEFS_W  = 60;
    localparam int WEIGHT_W = 16;
    localparam int FRAC_W   = 8;
    localparam int OPA_W    = 29;
    localparam int OPB_W    = 17;
    localparam int PROD_W   = OPA_W + OPB_W;
    localparam int STEP_W   = 3;

    // apb port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    // cost modes
    typedef logic [2:0] t_mode;
    localparam t_mode MODE_DIST_ROBOT = 3'd0;
    localparam t_mode MODE_BY_TYPE    = 3'd1;
    localparam t_mode MODE_DIST       = 3'd2;
    localparam t_mode MODE_ROBOT      = 3'd3;
    localparam t_mode MODE_QUAD       = 3'd4;

    // register indexes
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_COST_MODE = 2'd0;
    localparam t_reg_idx REG_WEIGHT    = 2'd1;
    localparam t_reg_idx REG_COEF_ST   = 2'd2;
    localparam t_reg_idx REG_COEF_EP   = 2'd3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

    // coefficient slots in a packed set
    typedef logic [STEP_W-1:0] t_slot;
    localparam t_slot SLOT_X2 = 3'd0;
    localparam t_slot SLOT_Y2 = 3'd1;
    localparam t_slot SLOT_XY = 3'd2;
    localparam t_slot SLOT_X  = 3'd3;
    localparam t_slot SLOT_Y  = 3'd4;

    localparam logic [STEP_W-1:0] QUAD_LAST_STEP = 3'd7;

    localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};

    // multiplier operand selects
    typedef enum logic [1:0] {
        A_X    = 2'd0,
        A_Y    = 2'd1,
        A_CNT  = 2'd2,
        A_PROD = 2'd3
    } t_a_sel;

    typedef enum logic [1:0] {
        B_COEF   = 2'd0,
        B_WEIGHT = 2'd1,
        B_X      = 2'd2,
        B_Y      = 2'd3
    } t_b_sel;

    // controller to datapath commands
    typedef struct packed {
        logic   load;
        logic   mul_en;
        t_a_sel a_sel;
        t_b_sel b_sel;
        t_slot  coef_slot;
        logic   acc_add;
        logic   cmp;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic emit_ok;
        logic last;
    } t_dp_sts;

    function automatic logic mode_is_quad(t_mode mode);
        return mode == MODE_QUAD;
    endfunction

    function automatic logic mode_uses_weight(t_mode mode);
        return (mode == MODE_DIST_ROBOT) || (mode == MODE_BY_TYPE);
    endfunction

    // starting accumulator value: the shifted distance or robot term, zero in the quadratic mode
    function automatic logic signed [COST_W-1:0] base_cost(t_mode mode,
                                                           logic [DIST_W-1:0] x,
                                                           logic [ROBOT_W-1:0] y);
        logic signed [COST_W-1:0] v;
        case (mode)
            MODE_ROBOT: v = {{(COST_W-ROBOT_W-FRAC_W){1'b0}}, y, {FRAC_W{1'b0}}};
            MODE_QUAD:  v = '0;
            default:    v = {{(COST_W-DIST_W-FRAC_W){1'b0}}, x, {FRAC_W{1'b0}}};
        endcase
        return v;
    endfunction

    // quadratic sequence: coefficient times one factor, then times the other,
    // each finished term added while the next product is formed
    function automatic t_dp_cmd quad_cmd(logic [STEP_W-1:0] step);
        t_dp_cmd c;
        c           = '0;
        c.mul_en    = 1'b1;
        c.b_sel     = B_COEF;
        case (step)
            3'd0: begin
                c.a_sel = A_X;    c.coef_slot = SLOT_X2;
            end
            3'd1: begin
                c.a_sel = A_PROD; c.b_sel = B_X;
            end
            3'd2: begin
                c.a_sel = A_Y;    c.coef_slot = SLOT_Y2; c.acc_add = 1'b1;
            end
            3'd3: begin
                c.a_sel = A_PROD; c.b_sel = B_Y;
            end
            3'd4: begin
                c.a_sel = A_X;    c.coef_slot = SLOT_XY; c.acc_add = 1'b1;
            end
            3'd5: begin
                c.a_sel = A_PROD; c.b_sel = B_Y;
            end
            3'd6: begin
                c.a_sel = A_X;    c.coef_slot = SLOT_X;  c.acc_add = 1'b1;
            end
            default: begin
                c.a_sel = A_Y;    c.coef_slot = SLOT_Y;  c.acc_add = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

/* sv/wmcts_regs.sv */
// apb configuration registers: cost mode, load weight, two coefficient sets
// depends on wmcts_pkg
`timescale 1ns / 1ps

module wmcts_regs import wmcts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    output t_mode               o_cost_mode,
    output logic [WEIGHT_W-1:0] o_load_weight,
    output logic [COEFS_W-1:0]  o_coef_st,
    output logic [COEFS_W-1:0]  o_coef_ep
);

    t_mode               r_cost_mode;
    logic [WEIGHT_W-1:0] r_load_weight;
    logic [COEFS_W-1:0]  r_coef_st;
    logic [COEFS_W-1:0]  r_coef_ep;
    t_reg_idx            w_idx;
    logic                w_wr;

    assign w_idx  = paddr[PADDR_W-1:PADDR_W-2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_mode   <= MODE_DIST_ROBOT;
            r_load_weight <= WEIGHT_RESET;
            r_coef_st     <= '0;
            r_coef_ep     <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_COST_MODE: r_cost_mode   <= pwdata[2:0];
                REG_WEIGHT:    r_load_weight <= pwdata[WEIGHT_W-1:0];
                REG_COEF_ST:   r_coef_st     <= pwdata[COEFS_W-1:0];
                REG_COEF_EP:   r_coef_ep     <= pwdata[COEFS_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_COST_MODE: prdata = {{(PDATA_W-3){1'b0}}, r_cost_mode};
            REG_WEIGHT:    prdata = {{(PDATA_W-WEIGHT_W){1'b0}}, r_load_weight};
            REG_COEF_ST:   prdata = {{(PDATA_W-COEFS_W){1'b0}}, r_coef_st};
            REG_COEF_EP:   prdata = {{(PDATA_W-COEFS_W){1'b0}}, r_coef_ep};
            default:       prdata = '0;
        endcase
    end

    assign o_cost_mode   = r_cost_mode;
    assign o_load_weight = r_load_weight;
    assign o_coef_st     = r_coef_st;
    assign o_coef_ep     = r_coef_ep;

endmodule

/* sv/wmcts_ctrl.sv */
// controller: sequences load, shared multiplier steps, final add and compare
// depends on wmcts_pkg
`timescale 1ns / 1ps

module wmcts_ctrl import wmcts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_mode   i_cost_mode,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_CMP  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               w_quad;
    logic               w_mul;

    assign w_quad = mode_is_quad(i_cost_mode);
    assign w_mul  = mode_uses_weight(i_cost_mode);

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = (w_quad || w_mul) ? S_MUL : S_CMP;
                end
            end
            S_MUL: begin
                if (w_quad) begin
                    o_cmd = quad_cmd(r_step);
                end else begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.a_sel  = A_CNT;
                    o_cmd.b_sel  = B_WEIGHT;
                end
                if (!w_quad || r_step == QUAD_LAST_STEP) begin
                    n_state = S_ACC;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                // a last request waits here while the previous result is held
                if (i_sts.emit_ok) begin
                    o_cmd.cmp = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* sv/wmcts_dp.sv */
// datapath: request registers, shared multiplier, cost accumulator,
// running minimum and result register; depends on wmcts_pkg
`timescale 1ns / 1ps

module wmcts_dp import wmcts_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  t_mode                     i_cost_mode,
    input  logic [WEIGHT_W-1:0]       i_load_weight,
    input  logic [COEFS_W-1:0]        i_coef_st,
    input  logic [COEFS_W-1:0]        i_coef_ep,
    input  logic [DIST_W-1:0]         i_distance,
    input  logic [ROBOT_W-1:0]        i_robot_count,
    input  logic [PKG_W-1:0]          i_package_count,
    input  logic                      i_is_endpoint,
    input  logic [LOC_W-1:0]          i_location,
    input  logic [BIN_W-1:0]          i_bin_number,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [LOC_W-1:0]          o_best_location,
    output logic [BIN_W-1:0]          o_best_bin,
    output logic signed [COST_W-1:0]  o_best_cost
);

    // request registers
    logic [DIST_W-1:0]          r_x;
    logic [ROBOT_W-1:0]         r_y;
    logic [PKG_W-1:0]           r_pk;
    logic                       r_ep;
    logic [LOC_W-1:0]           r_loc;
    logic [BIN_W-1:0]           r_bin;
    logic                       r_last;

    logic signed [PROD_W-1:0]   r_prod;
    logic signed [COST_W-1:0]   r_acc;
    logic signed [COST_W-1:0]   r_min;
    logic [LOC_W-1:0]           r_best_loc;
    logic [BIN_W-1:0]           r_best_bin;

    logic                       r_out_valid;
    logic [LOC_W-1:0]           r_out_loc;
    logic [BIN_W-1:0]           r_out_bin;
    logic signed [COST_W-1:0]   r_out_cost;

    logic [COEFS_W-1:0]         w_coef_set;
    logic [COEF_W-1:0]          w_coef;
    logic signed [OPA_W-1:0]    w_op_a;
    logic signed [OPB_W-1:0]    w_op_b;
    logic signed [PROD_W-1:0]   w_mul;
    logic signed [COST_W-1:0]   w_prod_ext;
    logic                       w_less;

    // coefficient pick by target type and slot
    assign w_coef_set = r_ep ? i_coef_ep : i_coef_st;

    always_comb begin
        case (i_cmd.coef_slot)
            SLOT_X2: w_coef = w_coef_set[0*COEF_W +: COEF_W];
            SLOT_Y2: w_coef = w_coef_set[1*COEF_W +: COEF_W];
            SLOT_XY: w_coef = w_coef_set[2*COEF_W +: COEF_W];
            SLOT_X:  w_coef = w_coef_set[3*COEF_W +: COEF_W];
            SLOT_Y:  w_coef = w_coef_set[4*COEF_W +: COEF_W];
            default: w_coef = '0;
        endcase
    end

    // multiplier operands
    always_comb begin
        case (i_cmd.a_sel)
            A_X:    w_op_a = {{(OPA_W-DIST_W){1'b0}}, r_x};
            A_Y:    w_op_a = {{(OPA_W-ROBOT_W){1'b0}}, r_y};
            A_CNT: begin
                // packages replace robots for an endpoint in the by-type mode
                if (i_cost_mode == MODE_BY_TYPE && r_ep) begin
                    w_op_a = {{(OPA_W-PKG_W){1'b0}}, r_pk};
                end else begin
                    w_op_a = {{(OPA_W-ROBOT_W){1'b0}}, r_y};
                end
            end
            A_PROD: w_op_a = r_prod[OPA_W-1:0];
            default: w_op_a = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.b_sel)
            B_COEF:   w_op_b = {{(OPB_W-COEF_W){w_coef[COEF_W-1]}}, w_coef};
            B_WEIGHT: w_op_b = {{(OPB_W-WEIGHT_W){1'b0}}, i_load_weight};
            B_X:      w_op_b = {{(OPB_W-DIST_W){1'b0}}, r_x};
            B_Y:      w_op_b = {{(OPB_W-ROBOT_W){1'b0}}, r_y};
            default:  w_op_b = '0;
        endcase
    end

    assign w_mul      = w_op_a * w_op_b;
    assign w_prod_ext = {{(COST_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_less     = r_acc < r_min;

    assign o_sts.emit_ok = !r_last || !r_out_valid || i_out_ready;
    assign o_sts.last    = r_last;

    // request capture, product and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_distance;
            r_y    <= i_robot_count;
            r_pk   <= i_package_count;
            r_ep   <= i_is_endpoint;
            r_loc  <= i_location;
            r_bin  <= i_bin_number;
            r_last <= i_last;
            r_acc  <= base_cost(i_cost_mode, i_distance, i_robot_count);
        end else if (i_cmd.acc_add) begin
            r_acc  <= r_acc + w_prod_ext;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul;
        end
    end

    // running minimum, cleared after each decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= COST_MAX;
            r_best_loc  <= '0;
            r_best_bin  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.cmp) begin
                if (r_last) begin
                    r_out_valid <= 1'b1;
                    r_min       <= COST_MAX;
                    r_best_loc  <= '0;
                    r_best_bin  <= '0;
                end else if (w_less) begin
                    r_min      <= r_acc;
                    r_best_loc <= r_loc;
                    r_best_bin <= r_bin;
                end
            end
        end
    end

    // result register, strict compare keeps the earlier candidate on a tie
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp && r_last) begin
            r_out_cost <= w_less ? r_acc : r_min;
            r_out_loc  <= w_less ? r_loc : r_best_loc;
            r_out_bin  <= w_less ? r_bin : r_best_bin;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_best_location = r_out_loc;
    assign o_best_bin      = r_out_bin;
    assign o_best_cost     = r_out_cost;

endmodule

/* sv/weighted_min_cost_target_select.sv */
// Minimum-cost target selector.
// Requests arrive on a valid/ready channel, one candidate target each; the
// request marked last closes a decision. The result channel (valid/ready)
// carries the location, bin and cost of the strictly cheapest candidate of
// the decision, the earliest one on a tie. Configuration is written over the
// APB port; the user must write it only while no request is in flight, as
// the block does not enforce this. pready is always high. Requests are taken
// one at a time through the one shared multiplier: each passes through load,
// the multiplier steps, the final add and the compare before the next one is
// accepted. The distance-only and robot-only modes go from load straight to
// compare, the weighted modes form one product and the quadratic mode eight.
// The result sits in an output register, so new requests are taken while it
// waits; only a further last request stalls until the held result is taken.
// Synchronous reset restores the register defaults, drops any held result
// and clears the running minimum. Depends on wmcts_pkg and its submodules.
`timescale 1ns / 1ps

module weighted_min_cost_target_select import wmcts_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [DIST_W-1:0]         i_distance,
    input  logic [ROBOT_W-1:0]        i_robot_count,
    input  logic [PKG_W-1:0]          i_package_count,
    input  logic                      i_is_endpoint,
    input  logic [LOC_W-1:0]          i_location,
    input  logic [BIN_W-1:0]          i_bin_number,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [LOC_W-1:0]          o_best_location,
    output logic [BIN_W-1:0]          o_best_bin,
    output logic signed [COST_W-1:0]  o_best_cost
);

    t_mode               w_cost_mode;
    logic [WEIGHT_W-1:0] w_load_weight;
    logic [COEFS_W-1:0]  w_coef_st;
    logic [COEFS_W-1:0]  w_coef_ep;
    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;

    // configuration registers
    wmcts_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_cost_mode   (w_cost_mode),
        .o_load_weight (w_load_weight),
        .o_coef_st     (w_coef_st),
        .o_coef_ep     (w_coef_ep)
    );

    // sequencer
    wmcts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cost_mode (w_cost_mode),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // cost arithmetic and running minimum
    wmcts_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cost_mode     (w_cost_mode),
        .i_load_weight   (w_load_weight),
        .i_coef_st       (w_coef_st),
        .i_coef_ep       (w_coef_ep),
        .i_distance      (i_distance),
        .i_robot_count   (i_robot_count),
        .i_package_count (i_package_count),
        .i_is_endpoint   (i_is_endpoint),
        .i_location      (i_location),
        .i_bin_number    (i_bin_number),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_best_location (o_best_location),
        .o_best_bin      (o_best_bin),
        .o_best_cost     (o_best_cost)
    );

endmodule

/* sv/wmcts_checker.sv */
// port-level checks on the target selector, attached by bind
// depends on wmcts_pkg and weighted_min_cost_target_select
`timescale 1ns / 1ps

module wmcts_checker import wmcts_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     pready,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     i_last,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [LOC_W-1:0]         o_best_location,
    input logic [BIN_W-1:0]         o_best_bin,
    input logic signed [COST_W-1:0] o_best_cost
);

    // reset drops any held result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_best_location) && $stable(o_best_bin) &&
            $stable(o_best_cost))
        else $error("held result changed");

    // one request at a time: ready drops after each accepted request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    // a request that is not last never raises a result right after it
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && o_in_ready && !i_last |=> !$rose(o_out_valid))
        else $error("result without last request");

    // config port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind weighted_min_cost_target_select wmcts_checker u_wmcts_checker (.*);

/* dv/tb_weighted_min_cost_target_select.sv */
// testbench for weighted_min_cost_target_select: random and directed candidate requests,
// apb register settings across every cost mode, results checked against an in-bench predictor
// depends on wmcts_pkg and the selector rtl
`timescale 1ns / 1ps

module tb_weighted_min_cost_target_select;
    import wmcts_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [DIST_W-1:0]  travel;
        logic [ROBOT_W-1:0] robots;
        logic [PKG_W-1:0]   pkgs;
        logic               endpoint;
        logic [LOC_W-1:0]   loc;
        logic [BIN_W-1:0]   bin;
        logic               last;
    } t_cand;

    typedef struct {
        logic [LOC_W-1:0]         loc;
        logic [BIN_W-1:0]         bin;
        logic signed [COST_W-1:0] cost;
    } t_winner;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [DIST_W-1:0]    i_distance = '0;
    logic [ROBOT_W-1:0]   i_robot_count = '0;
    logic [PKG_W-1:0]     i_package_count = '0;
    logic                 i_is_endpoint = 1'b0;
    logic [LOC_W-1:0]     i_location = '0;
    logic [BIN_W-1:0]     i_bin_number = '0;
    logic                 i_last = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [LOC_W-1:0]     o_best_location;
    logic [BIN_W-1:0]     o_best_bin;
    logic signed [COST_W-1:0] o_best_cost;

    // predictor copy of the registers and the running minimum
    t_mode                cfg_mode = MODE_DIST_ROBOT;
    logic [WEIGHT_W-1:0]  cfg_weight = WEIGHT_RESET;
    logic [COEFS_W-1:0]   cfg_coef_st = '0;
    logic [COEFS_W-1:0]   cfg_coef_ep = '0;
    longint               run_min_cost = COST_MAX;
    logic [LOC_W-1:0]     run_best_loc = '0;
    logic [BIN_W-1:0]     run_best_bin = '0;

    t_cand   cand_queue[$];
    t_winner pending_winners[$];

    bit calm = 1'b0;
    int n_errors = 0;
    int n_requests = 0;
    int n_decisions = 0;
    int n_settings = 1;
    int stall_cycles = 0;

    weighted_min_cost_target_select u_dut (.*);

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 16);
    endfunction

    function automatic longint coef_of(logic [COEFS_W-1:0] set, t_slot slot);
        logic signed [COEF_W-1:0] c;
        c = set[slot*COEF_W +: COEF_W];
        return c;
    endfunction

    // cost of one candidate under the current register settings
    function automatic longint target_cost(t_cand c);
        longint x, y, k, w;
        logic [COEFS_W-1:0] set;
        x = c.travel;
        y = c.robots;
        k = c.endpoint ? c.pkgs : c.robots;
        w = cfg_weight;
        set = c.endpoint ? cfg_coef_ep : cfg_coef_st;
        case (cfg_mode)
            MODE_DIST_ROBOT: return (x << FRAC_W) + w * y;
            MODE_BY_TYPE:    return (x << FRAC_W) + w * k;
            MODE_ROBOT:      return y << FRAC_W;
            MODE_QUAD:       return coef_of(set, SLOT_X2) * x * x + coef_of(set, SLOT_Y2) * y * y
                                  + coef_of(set, SLOT_XY) * x * y + coef_of(set, SLOT_X) * x
                                  + coef_of(set, SLOT_Y) * y;
            default:         return x << FRAC_W;
        endcase
    endfunction

    task automatic note_mismatch(string what, longint got, longint want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_requests
        t_cand c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (cand_queue.size() != 0 && !take_break()) begin
                c = cand_queue.pop_front();
                i_distance      <= c.travel;
                i_robot_count   <= c.robots;
                i_package_count <= c.pkgs;
                i_is_endpoint   <= c.endpoint;
                i_location      <= c.loc;
                i_bin_number    <= c.bin;
                i_last          <= c.last;
                i_in_valid      <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !take_break();
        end
    end

    // track accepted requests through the predictor
    always @(posedge i_clk) begin : predict_winner
        t_cand c;
        longint cost;
        t_winner w;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            c.travel = i_distance;
            c.robots = i_robot_count;
            c.pkgs = i_package_count;
            c.endpoint = i_is_endpoint;
            c.loc = i_location;
            c.bin = i_bin_number;
            c.last = i_last;
            n_requests++;
            cost = target_cost(c);
            // strictly lower wins, so the earlier candidate keeps a tie
            if (cost < run_min_cost) begin
                run_min_cost = cost;
                run_best_loc = c.loc;
                run_best_bin = c.bin;
            end
            if (c.last) begin
                w.loc = run_best_loc;
                w.bin = run_best_bin;
                w.cost = run_min_cost[COST_W-1:0];
                pending_winners.insert(pending_winners.size(), w);
                run_min_cost = COST_MAX;
                run_best_loc = '0;
                run_best_bin = '0;
            end
        end
    end

    // compare each result with the oldest expected winner
    always @(posedge i_clk) begin : check_winner
        t_winner w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_winners.size() == 0) begin
                note_mismatch("unexpected result count", 1, 0);
            end else begin
                w = pending_winners.pop_front();
                n_decisions++;
                if (o_best_location !== w.loc)
                    note_mismatch("best_location", o_best_location, w.loc);
                if (o_best_bin !== w.bin)
                    note_mismatch("best_bin", o_best_bin, w.bin);
                if (o_best_cost !== w.cost)
                    note_mismatch("best_cost", longint'(o_best_cost), longint'(w.cost));
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // wait until every request is taken and every winner has come back
    task automatic settle();
        do @(negedge i_clk);
        while (cand_queue.size() != 0 || i_in_valid || pending_winners.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COST_MODE: cfg_mode = value[2:0];
            REG_WEIGHT:    cfg_weight = value[WEIGHT_W-1:0];
            REG_COEF_ST:   cfg_coef_st = value[COEFS_W-1:0];
            default:       cfg_coef_ep = value[COEFS_W-1:0];
        endcase
    endtask

    task automatic configure(logic [2:0] mode, logic [WEIGHT_W-1:0] weight,
                             logic [COEFS_W-1:0] cst, logic [COEFS_W-1:0] cep);
        settle();
        write_reg(REG_COST_MODE, PDATA_W'(mode));
        write_reg(REG_WEIGHT, PDATA_W'(weight));
        write_reg(REG_COEF_ST, PDATA_W'(cst));
        write_reg(REG_COEF_EP, PDATA_W'(cep));
        n_settings++;
    endtask

    task automatic queue_cand(int travel, int robots, int pkgs, bit ep, int loc, int bin,
                              bit last);
        t_cand c;
        c.travel = DIST_W'(travel);
        c.robots = ROBOT_W'(robots);
        c.pkgs = PKG_W'(pkgs);
        c.endpoint = ep;
        c.loc = LOC_W'(loc);
        c.bin = BIN_W'(bin);
        c.last = last;
        cand_queue.insert(cand_queue.size(), c);
    endtask

    // biased toward the ends of the range and small values, so ties occur
    function automatic int rand_field(int unsigned maxv);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return maxv;
            2:       return $urandom_range(0, 3);
            default: return $urandom_range(0, maxv);
        endcase
    endfunction

    function automatic logic [COEFS_W-1:0] rand_coefs();
        logic [COEFS_W-1:0] s;
        for (int k = 0; k < 5; k++) begin
            case ($urandom_range(0, 4))
                0:       s[k*COEF_W +: COEF_W] = 12'h800;
                1:       s[k*COEF_W +: COEF_W] = 12'h7FF;
                2:       s[k*COEF_W +: COEF_W] = '0;
                default: s[k*COEF_W +: COEF_W] = COEF_W'($urandom);
            endcase
        end
        return s;
    endfunction

    // whole decisions of random length with random candidates
    task automatic queue_random(int n_items);
        int len;
        int done;
        done = 0;
        while (done < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                queue_cand(rand_field(16'hFFFF), rand_field(10'h3FF), rand_field(12'hFFF),
                           $urandom_range(0, 1), rand_field(16'hFFFF), rand_field(12'hFFF),
                           k == len - 1);
            done += len;
        end
    endtask

    // stimulus and end of run
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: lone candidate at the field maxima, a tie, a lone zero candidate
        queue_cand(16'hFFFF, 10'h3FF, 12'hFFF, 1, 16'hFFFF, 12'hFFF, 1);
        queue_cand(10, 0, 5, 0, 16'h0001, 12'h001, 0);
        queue_cand(9, 1, 7, 1, 16'h0002, 12'h002, 0);
        queue_cand(12, 0, 0, 0, 16'h0003, 12'h003, 1);
        queue_cand(0, 0, 0, 0, 0, 0, 1);
        queue_random(60);

        // by-type mode with the largest weight: packages count only for endpoints
        configure(MODE_BY_TYPE, 16'hFFFF, '0, '0);
        queue_cand(100, 0, 12'hFFF, 1, 16'h1111, 12'h111, 0);
        queue_cand(100, 10'h3FF, 0, 0, 16'h2222, 12'h222, 0);
        queue_cand(100, 10'h3FF, 0, 1, 16'h3333, 12'h333, 1);
        queue_random(40);
        // sender holds off until every winner is back
        settle();
        queue_random(40);

        configure(MODE_BY_TYPE, 16'h0000, '0, '0);
        queue_random(50);
        configure(MODE_DIST, 16'h0100, '0, '0);
        queue_random(60);
        configure(MODE_ROBOT, 16'h8000, '0, '0);
        queue_random(60);

        // quadratic with the most negative and most positive coefficient sets
        configure(MODE_QUAD, 16'h0100, {5{12'h800}}, {5{12'h7FF}});
        queue_cand(16'hFFFF, 10'h3FF, 0, 0, 16'hAAAA, 12'hAAA, 0);
        queue_cand(16'hFFFF, 10'h3FF, 0, 1, 16'h5555, 12'h555, 1);
        queue_cand(16'hFFFF, 10'h3FF, 12'hFFF, 1, 16'hFFFE, 12'hFFE, 1);
        queue_random(40);
        for (int k = 0; k < 4; k++) begin
            configure(MODE_QUAD, 16'($urandom), rand_coefs(), rand_coefs());
            queue_random(40);
        end

        // unused mode codes fall back to distance alone
        for (int m = 5; m < 8; m++) begin
            configure(3'(m), 16'($urandom), rand_coefs(), rand_coefs());
            queue_random(30);
        end

        // back-to-back stretch with no idling on either side
        configure(MODE_DIST_ROBOT, 16'($urandom), rand_coefs(), rand_coefs());
        calm = 1'b1;
        queue_random(120);
        settle();
        calm = 1'b0;

        $display("covered %0d candidate requests and %0d decisions over %0d register settings",
                 n_requests, n_decisions, n_settings);
        if (n_errors == 0 && pending_winners.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d errors, %0d winners never seen", n_errors, pending_winners.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/wmcts_pkg.sv
sv/wmcts_regs.sv
sv/wmcts_ctrl.sv
sv/wmcts_dp.sv
sv/weighted_min_cost_target_select.sv
sv/wmcts_checker.sv
dv/tb_weighted_min_cost_target_select.sv
